// ===== rtl/sorted_priority_queue_top_defines.svh =====
// Assertion macros for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spq check failed");

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spq check failed");

`endif

// ===== rtl/spq_pkg.sv =====
// Package: types and constants of the sorted priority queue
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic               op;
        logic signed [31:0] value;
        logic signed [15:0] priority_req;
    } req_word_t;

    typedef struct packed {
        logic signed [31:0] removed_value;
        logic [1:0]         status;
        logic [CNT_W-1:0]   occupancy;
    } rsp_word_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [15:0] prio;
    } entry_t;

    typedef struct packed {
        logic   shift_in;
        logic   shift_out;
        entry_t new_entry;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, shifts toward tail on insert, toward head on remove
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
    input  wire logic               clk,
    input  wire spq_pkg::cell_ctl_t ctl,
    input  wire logic               occ,
    input  wire logic               left_keep,
    input  wire spq_pkg::entry_t    left_entry,
    input  wire spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t         entry,
    output logic                    keep
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // entry stays when it is ahead of (or ties with) the new one
    assign keep  = occ && ($signed(entry_reg.prio) <= $signed(ctl.new_entry.prio));
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.shift_in && !keep)
        begin
            if (left_keep)
            begin
                entry_next = ctl.new_entry;
            end
            else
            begin
                entry_next = left_entry;
            end
        end
        else if (ctl.shift_out)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue_top.sv =====
// Top level of the sorted priority queue: cell chain, fill count and result register
//
// Bounded priority queue of CAPACITY entries kept sorted in a row of cells,
// smallest priority number at the head, equal priorities in arrival order.
// Every accepted word gives one result word in the next cycle. All cells
// compare against the incoming priority and shift in the same cycle, so a
// new word is taken every cycle; the result register decouples the sides
// and req_stall only rises while a result is held by rsp_stall.
// Entry storage has no reset; the fill count alone marks occupied cells.
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_priority_queue_top_defines.svh"

module sorted_priority_queue_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire spq_pkg::req_word_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output spq_pkg::rsp_word_t      rsp
);
    import spq_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_word_t        rsp_reg;
    rsp_word_t        rsp_next;

    logic             req_acc;
    logic             is_full;
    logic             is_empty;
    cell_ctl_t        ctl;

    entry_t           cell_entry [CAPACITY];
    logic             cell_keep  [CAPACITY];
    logic             cell_occ   [CAPACITY];

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign req_acc   = req_valid && !req_stall;
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign is_empty  = (count_reg == '0);

    assign ctl.shift_in        = req_acc && (req.op == OP_INSERT) && !is_full;
    assign ctl.shift_out       = req_acc && (req.op == OP_REMOVE) && !is_empty;
    assign ctl.new_entry.value = req.value;
    assign ctl.new_entry.prio  = req.priority_req;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            assign cell_occ[gi] = (CNT_W'(gi) < count_reg);
            if (gi == 0)
            begin : g_head
                if (CAPACITY > 1)
                begin : g_more
                    spq_cell u_cell (
                        .clk         (clk),
                        .ctl         (ctl),
                        .occ         (cell_occ[gi]),
                        .left_keep   (1'b1),
                        .left_entry  (ctl.new_entry),
                        .right_entry (cell_entry[gi+1]),
                        .entry       (cell_entry[gi]),
                        .keep        (cell_keep[gi])
                    );
                end
            end
            else if (gi == CAPACITY - 1)
            begin : g_tail
                spq_cell u_cell (
                    .clk         (clk),
                    .ctl         (ctl),
                    .occ         (cell_occ[gi]),
                    .left_keep   (cell_keep[gi-1]),
                    .left_entry  (cell_entry[gi-1]),
                    .right_entry (entry_t'('0)),
                    .entry       (cell_entry[gi]),
                    .keep        (cell_keep[gi])
                );
            end
            else
            begin : g_mid
                spq_cell u_cell (
                    .clk         (clk),
                    .ctl         (ctl),
                    .occ         (cell_occ[gi]),
                    .left_keep   (cell_keep[gi-1]),
                    .left_entry  (cell_entry[gi-1]),
                    .right_entry (cell_entry[gi+1]),
                    .entry       (cell_entry[gi]),
                    .keep        (cell_keep[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        count_next             = count_reg;
        rsp_next               = rsp_reg;
        rsp_valid_next         = rsp_valid_reg && rsp_stall;
        if (req_acc)
        begin
            rsp_valid_next         = 1'b1;
            rsp_next.removed_value = '0;
            rsp_next.status        = ST_OK;
            if (req.op == OP_INSERT)
            begin
                if (is_full)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            else
            begin
                if (is_empty)
                begin
                    rsp_next.status = ST_UNDERFLOW;
                end
                else
                begin
                    rsp_next.removed_value = cell_entry[0].value;
                    count_next             = count_reg - CNT_W'(1);
                end
            end
            rsp_next.occupancy = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `SPQ_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `SPQ_ASSERT_NEXT(a_full_drop, req_acc && (req.op == OP_INSERT) && is_full, (rsp_reg.status == ST_FULL) && (count_reg == CNT_W'(CAPACITY)))
    `SPQ_ASSERT_NOW(a_underflow, rsp_valid_reg && (rsp_reg.status == ST_UNDERFLOW), (rsp_reg.removed_value == '0) && (rsp_reg.occupancy == '0))
    `SPQ_ASSERT_NOW(a_head_sorted, count_reg >= CNT_W'(2), $signed(cell_entry[0].prio) <= $signed(cell_entry[1].prio))

endmodule

`default_nettype wire
